### rtl/compass_heading_steering_top_macros.svh
// ----------------------------------------------------------------------------
// compass heading steering assertion macros
// shared property wrappers for the compass heading steering block
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_STEERING_TOP_MACROS_SVH
`define COMPASS_HEADING_STEERING_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// types, constants and the arctangent table of the compass heading block
// ----------------------------------------------------------------------------
package chs_pkg;

   // cordic iteration count, capped at the table length
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam int ITER_W       = $clog2(TABLE_LEN);

   // datapath widths
   localparam int MAG_W  = 16;
   localparam int CFG_W  = 16;
   localparam int TGT_W  = 9;
   localparam int CAL_W  = 18;
   localparam int XY_W   = 21;
   localparam int Z_W    = 26;
   localparam int HD_W   = 17;
   localparam int OUT_W  = 15;
   localparam int STR_W  = 18;
   localparam int IDX_W  = 3;

   // fixed-point constants
   localparam logic signed [CAL_W-1:0] SAT_MAX = CAL_W'(131071);
   localparam logic signed [CAL_W-1:0] SAT_MIN = -CAL_W'(131072);
   localparam logic signed [Z_W-1:0]   Z_QUARTER = Z_W'(90 * 65536);
   localparam logic signed [Z_W-1:0]   Z_ROUND   = Z_W'(512);
   localparam logic signed [HD_W-1:0]  FULL_TURN = HD_W'(23040);
   localparam logic [TGT_W-1:0]        DEAD_BAND = TGT_W'(5);
   localparam logic signed [STR_W-1:0] REVERSE_GAP = STR_W'(181 * 64);
   localparam logic [15:0]             SCALE_ONE = 16'd4096;

   typedef enum logic [IDX_W-1:0] {
      REG_BIAS_X = 3'd0,
      REG_BIAS_Y = 3'd1,
      REG_SCALE_X = 3'd2,
      REG_SCALE_Y = 3'd3,
      REG_TARGET = 3'd4
   } chs_reg_type;

   typedef enum logic [1:0] {
      STEER_NONE  = 2'd0,
      STEER_RIGHT = 2'd1,
      STEER_LEFT  = 2'd2
   } steer_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALX,
      S_CALY,
      S_PREP,
      S_ITER,
      S_DONE
   } chs_state_type;

   typedef struct packed {
      logic              load;
      logic              cal_x;
      logic              cal_y;
      logic              prep;
      logic              iter;
      logic              finish;
      logic [ITER_W-1:0] iter_idx;
   } chs_cmd_type;

   typedef struct packed {
      logic out_free;
      logic out_full;
   } chs_status_type;

   // round(atan(2^-i) * 180/pi * 65536)
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:  v = Z_W'(2949120);
         5'd1:  v = Z_W'(1740967);
         5'd2:  v = Z_W'(919879);
         5'd3:  v = Z_W'(466945);
         5'd4:  v = Z_W'(234379);
         5'd5:  v = Z_W'(117304);
         5'd6:  v = Z_W'(58666);
         5'd7:  v = Z_W'(29335);
         5'd8:  v = Z_W'(14668);
         5'd9:  v = Z_W'(7334);
         5'd10: v = Z_W'(3667);
         5'd11: v = Z_W'(1833);
         5'd12: v = Z_W'(917);
         5'd13: v = Z_W'(458);
         5'd14: v = Z_W'(229);
         5'd15: v = Z_W'(115);
         5'd16: v = Z_W'(57);
         5'd17: v = Z_W'(29);
         5'd18: v = Z_W'(14);
         5'd19: v = Z_W'(7);
         5'd20: v = Z_W'(4);
         5'd21: v = Z_W'(2);
         5'd22: v = Z_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### rtl/chs_ctrl.sv
// ----------------------------------------------------------------------------
// chs_ctrl
// sequencer: calibration, cordic iterations and result hand-off
// ----------------------------------------------------------------------------
module chs_ctrl
   import chs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  chs_status_type status,
   output chs_cmd_type    cmd
);

`include "compass_heading_steering_top_macros.svh"

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

   chs_state_type     state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CALX;
            end
         end
         S_CALX: state_in = S_CALY;
         S_CALY: state_in = S_PREP;
         S_PREP: begin
            state_in = S_ITER;
            iter_in  = '0;
         end
         S_ITER: begin
            if (iter_ff == ITER_LAST) begin
               state_in = S_DONE;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.iter_idx = iter_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_CALX: cmd.cal_x = 1'b1;
         S_CALY: cmd.cal_y = 1'b1;
         S_PREP: cmd.prep  = 1'b1;
         S_ITER: cmd.iter  = 1'b1;
         S_DONE: cmd.finish = status.out_free;
         default: ;
      endcase
   end

   `CHS_ASSERT_IMPLY(a_iter_range, clock, reset, state_ff == S_ITER, iter_ff <= ITER_LAST, "iteration index past last step")
   `CHS_ASSERT_IMPLY(a_finish_free, clock, reset, cmd.finish, status.out_free && !status.out_full || status.out_free, "result loaded over a waiting result")
   `CHS_ASSERT_NEXT(a_accept_start, clock, reset, req_valid && req_ready, state_ff == S_CALX, "accepted beat did not start calibration")

endmodule

### rtl/chs_datapath.sv
// ----------------------------------------------------------------------------
// chs_datapath
// calibration, cordic vectoring, heading and steering, result register
// ----------------------------------------------------------------------------
module chs_datapath
   import chs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]        csr_data,
   input  logic signed [MAG_W-1:0] req_mag_x,
   input  logic signed [MAG_W-1:0] req_mag_y,
   input  chs_cmd_type             cmd,
   output chs_status_type          status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [OUT_W-1:0]        rsp_heading_out,
   output logic [1:0]              rsp_steer
);

`include "compass_heading_steering_top_macros.svh"

   logic signed [CFG_W-1:0] bias_x_ff, bias_y_ff;
   logic [CFG_W-1:0]        scale_x_ff, scale_y_ff;
   logic [TGT_W-1:0]        target_ff;
   logic signed [MAG_W-1:0] mag_x_ff, mag_y_ff;
   logic signed [CAL_W-1:0] cx_ff, cy_ff;
   logic signed [XY_W-1:0]  x_ff, y_ff;
   logic signed [Z_W-1:0]   z_ff;
   logic                    zero_ff;
   steer_type               last_steer_ff;
   logic                    rsp_valid_ff;
   logic [OUT_W-1:0]        heading_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_x_ff  <= '0;
         bias_y_ff  <= '0;
         scale_x_ff <= SCALE_ONE;
         scale_y_ff <= SCALE_ONE;
         target_ff  <= '0;
      end else if (csr_valid) begin
         case (chs_reg_type'(csr_index))
            REG_BIAS_X:  bias_x_ff  <= csr_data;
            REG_BIAS_Y:  bias_y_ff  <= csr_data;
            REG_SCALE_X: scale_x_ff <= csr_data;
            REG_SCALE_Y: scale_y_ff <= csr_data;
            REG_TARGET:  target_ff  <= csr_data[TGT_W-1:0];
            default: ;
         endcase
      end
   end

   // shared calibration multiplier
   logic signed [MAG_W:0]     diff;
   logic signed [2*MAG_W+1:0] prod;
   logic signed [2*MAG_W+1:0] prod_sh;
   logic signed [CAL_W-1:0]   cal_sat;

   always_comb begin
      if (cmd.cal_y) begin
         diff = (MAG_W+1)'(mag_y_ff) - (MAG_W+1)'(bias_y_ff);
         prod = (2*MAG_W+2)'(diff) * $signed({1'b0, scale_y_ff});
      end else begin
         diff = (MAG_W+1)'(mag_x_ff) - (MAG_W+1)'(bias_x_ff);
         prod = (2*MAG_W+2)'(diff) * $signed({1'b0, scale_x_ff});
      end
      prod_sh = prod >>> 12;
      if (prod_sh > (2*MAG_W+2)'(SAT_MAX)) begin
         cal_sat = SAT_MAX;
      end else if (prod_sh < (2*MAG_W+2)'(SAT_MIN)) begin
         cal_sat = SAT_MIN;
      end else begin
         cal_sat = prod_sh[CAL_W-1:0];
      end
   end

   // cordic pre-rotation and one vectoring step
   logic signed [XY_W-1:0] cx_w, cy_w, dx, dy;
   logic signed [Z_W-1:0]  atan_w;

   assign cx_w   = XY_W'(cx_ff);
   assign cy_w   = XY_W'(cy_ff);
   assign dx     = y_ff >>> cmd.iter_idx;
   assign dy     = x_ff >>> cmd.iter_idx;
   assign atan_w = atan_entry(cmd.iter_idx);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_x_ff <= req_mag_x;
         mag_y_ff <= req_mag_y;
      end
      if (cmd.cal_x) begin
         cx_ff <= cal_sat;
      end
      if (cmd.cal_y) begin
         cy_ff <= cal_sat;
      end
      if (cmd.prep) begin
         zero_ff <= (cx_ff == '0) && (cy_ff == '0);
         if (cx_ff < 0) begin
            if (cy_ff >= 0) begin
               x_ff <= cy_w;
               y_ff <= -cx_w;
               z_ff <= Z_QUARTER;
            end else begin
               x_ff <= -cy_w;
               y_ff <= cx_w;
               z_ff <= -Z_QUARTER;
            end
         end else begin
            x_ff <= cx_w;
            y_ff <= cy_w;
            z_ff <= '0;
         end
      end else if (cmd.iter) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_w;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_w;
         end
      end
   end

   // heading and steering
   logic signed [Z_W-1:0]   z_round, z_sh;
   logic signed [HD_W-1:0]  h_raw, h_fix;
   logic signed [STR_W-1:0] h_s, t64, lo64, hi64, gap;
   steer_type               s_band, s_new;

   always_comb begin
      z_round = (zero_ff ? '0 : z_ff) + Z_ROUND;
      z_sh    = z_round >>> 10;
      h_raw   = z_sh[HD_W-1:0];
      h_fix   = (h_raw <= 0) ? h_raw + FULL_TURN : h_raw;
      h_s     = STR_W'(h_fix);
      t64     = STR_W'({target_ff, 6'b0});
      lo64    = STR_W'({target_ff - DEAD_BAND, 6'b0});
      hi64    = STR_W'({1'b0, target_ff} + {1'b0, DEAD_BAND}) <<< 6;
      gap     = (h_s >= t64) ? h_s - t64 : t64 - h_s;
      if (h_s < lo64) begin
         s_band = STEER_RIGHT;
      end else if (h_s > hi64) begin
         s_band = STEER_LEFT;
      end else begin
         s_band = STEER_NONE;
      end
      s_new = s_band;
      if (gap >= REVERSE_GAP) begin
         case (s_band)
            STEER_RIGHT: s_new = STEER_LEFT;
            STEER_LEFT:  s_new = STEER_RIGHT;
            default:     s_new = s_band;
         endcase
      end
      if (target_ff < DEAD_BAND) begin
         s_new = last_steer_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_steer_ff <= STEER_NONE;
         rsp_valid_ff  <= 1'b0;
      end else if (cmd.finish) begin
         last_steer_ff <= s_new;
         rsp_valid_ff  <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         heading_ff <= h_fix[OUT_W-1:0];
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.out_full = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_heading_out = heading_ff;
   assign rsp_steer       = last_steer_ff;

   `CHS_ASSERT_IMPLY(a_heading_nonzero, clock, reset, rsp_valid_ff, heading_ff != '0, "heading outside its range")
   `CHS_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid_ff, "finished item did not show a result")

endmodule

### rtl/compass_heading_steering_top.sv
// ----------------------------------------------------------------------------
// compass_heading_steering_top
// calibrated magnetometer heading with dead-band steering against a target
// ----------------------------------------------------------------------------
// steps: x and y calibration multiplies on one shared multiplier, one pre-rotate,
//   16 cordic iterations on one shared add/shift unit, then the finish; a new
//   req beat is taken only once the sequencer is back in idle
// the next req beat is taken while the previous rsp beat still waits
// reset: synchronous, active high; registers return to their reset values,
//   last steer clears to no arrow, no rsp beat pending
module compass_heading_steering_top
   import chs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // configuration write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]        csr_data,
   // sample channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [MAG_W-1:0] req_mag_x,
   input  logic signed [MAG_W-1:0] req_mag_y,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [OUT_W-1:0]        rsp_heading_out,
   output logic [1:0]              rsp_steer
);

   chs_cmd_type    cmd;
   chs_status_type status;

   // configuration writes are registered and always taken
   assign csr_ready = 1'b1;

   // sequencer: walks calibration, cordic steps and the result hand-off
   chs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: config registers, shared multiplier, cordic unit, result register
   chs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_mag_x       (req_mag_x),
      .req_mag_y       (req_mag_y),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_heading_out (rsp_heading_out),
      .rsp_steer       (rsp_steer)
   );

endmodule
